@@ src/msort_pkg.sv @@
// ----------------------------------------------------------------------------
// msort_pkg
// Shared types and defaults of the merge sort engine.
// ----------------------------------------------------------------------------
package msort_pkg;

   localparam int MAX_ITEMS_DEF  = 64;
   localparam int DATA_WIDTH_DEF = 32;

   // controls broadcast from the sequencer to every cell
   typedef struct packed {
      logic load;   // insert the broadcast value in order
      logic shift;  // move every entry one cell towards the output
   } cell_ctrl_type;

endpackage

@@ src/msort_cell.sv @@
// ----------------------------------------------------------------------------
// msort_cell
// One slot of the ordered chain: holds an element and its valid flag.
// ----------------------------------------------------------------------------
module msort_cell #(
   parameter int DATA_WIDTH = msort_pkg::DATA_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  msort_pkg::cell_ctrl_type ctrl,
   input  logic [DATA_WIDTH-1:0]   new_value,
   input  logic [DATA_WIDTH-1:0]   left_value,
   input  logic                    left_valid,
   input  logic                    left_take,
   input  logic [DATA_WIDTH-1:0]   right_value,
   input  logic                    right_valid,
   output logic [DATA_WIDTH-1:0]   value,
   output logic                    valid,
   output logic                    take
);
   import msort_pkg::*;

   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic                  valid_ff, valid_in;

   // the new element belongs at or before this slot
   assign take = !valid_ff || ($signed(new_value) < $signed(value_ff));

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.shift) begin
         value_in = right_value;
         valid_in = right_valid;
      end else if (ctrl.load && take) begin
         // left neighbour also takes: its old entry moves in here
         if (left_take) begin
            value_in = left_value;
            valid_in = left_valid;
         end else begin
            value_in = new_value;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

@@ src/merge_sort_engine.sv @@
// ----------------------------------------------------------------------------
// merge_sort_engine
// Sorts one set of signed elements into ascending order on a chain of cells.
// ----------------------------------------------------------------------------
// Each element is placed in order on arrival; once the chain is full, it sets the overflow flag instead.
// The first result is offered in the cycle after the last input beat, then
// one result per cycle while rsp_tready is high.
// No input is taken while results drain; the next set starts after the final one.
// Reset empties every cell and clears the count, the overflow flag and the state.
// ----------------------------------------------------------------------------
module merge_sort_engine #(
   parameter int MAX_ITEMS  = msort_pkg::MAX_ITEMS_DEF,
   parameter int DATA_WIDTH = msort_pkg::DATA_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((DATA_WIDTH+7)/8)*8-1:0]     req_tdata,  // value
   input  logic                                req_tlast,  // last_item
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((DATA_WIDTH+7)/8)*8-1:0]     rsp_tdata,  // sorted_value
   output logic                                rsp_tlast,  // last_out
   output logic                                rsp_tuser   // overflowed
);
   import msort_pkg::*;

   localparam int TDATA_WIDTH = ((DATA_WIDTH + 7) / 8) * 8;
   localparam int COUNT_WIDTH = $clog2(MAX_ITEMS + 1);

   localparam logic ST_LOAD  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic                   state_ff, state_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   overflow_ff, overflow_in;

   logic                  in_beat, out_beat, store_full;
   logic [DATA_WIDTH-1:0] new_value;
   cell_ctrl_type         ctrl;

   logic [DATA_WIDTH-1:0] cell_value [MAX_ITEMS];
   logic [MAX_ITEMS-1:0]  cell_valid;
   logic [MAX_ITEMS-1:0]  cell_take;

   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = (state_ff == ST_DRAIN);
   assign in_beat    = req_tvalid && req_tready;
   assign out_beat   = rsp_tvalid && rsp_tready;
   assign store_full = (count_ff == COUNT_WIDTH'(MAX_ITEMS));
   assign new_value  = req_tdata[DATA_WIDTH-1:0];

   assign ctrl.load  = in_beat && !store_full;
   assign ctrl.shift = out_beat;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
         logic [DATA_WIDTH-1:0] lval, rval;
         logic                  lvld, ltake, rvld;
         if (gi == 0) begin : g_first
            assign lval  = '0;
            assign lvld  = 1'b0;
            assign ltake = 1'b0;
         end else begin : g_mid
            assign lval  = cell_value[gi-1];
            assign lvld  = cell_valid[gi-1];
            assign ltake = cell_take[gi-1];
         end
         if (gi == MAX_ITEMS - 1) begin : g_end
            assign rval = '0;
            assign rvld = 1'b0;
         end else begin : g_inner
            assign rval = cell_value[gi+1];
            assign rvld = cell_valid[gi+1];
         end
         msort_cell #(
            .DATA_WIDTH (DATA_WIDTH)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .new_value   (new_value),
            .left_value  (lval),
            .left_valid  (lvld),
            .left_take   (ltake),
            .right_value (rval),
            .right_valid (rvld),
            .value       (cell_value[gi]),
            .valid       (cell_valid[gi]),
            .take        (cell_take[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      case (state_ff)
         ST_LOAD: begin
            if (in_beat) begin
               if (store_full) begin
                  overflow_in = 1'b1;
               end else begin
                  count_in = count_ff + COUNT_WIDTH'(1);
               end
               if (req_tlast) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (out_beat && rsp_tlast) begin
               state_in    = ST_LOAD;
               count_in    = '0;
               overflow_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   // head of the chain is the smallest remaining element
   assign rsp_tdata = TDATA_WIDTH'(cell_value[0]);
   assign rsp_tlast = !cell_valid[1];
   assign rsp_tuser = overflow_ff;

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> cell_valid[0])
      else $error("result offered from an empty head cell");

   a_count_match: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> ($countones(cell_valid) == int'(count_ff)))
      else $error("element count disagrees with occupied cells");

   a_drain_done: assert property (@(posedge clock) disable iff (reset)
      (out_beat && rsp_tlast) |=> (!rsp_tvalid && (cell_valid == '0)))
      else $error("chain not empty after final result beat");

   a_sorted_head: assert property (@(posedge clock) disable iff (reset)
      (cell_valid[0] && cell_valid[1]) |->
         ($signed(cell_value[0]) <= $signed(cell_value[1])))
      else $error("chain head out of order");

endmodule
